FILE: rtl/ipvf_pkg.sv
// ============================================================================
// ipvf_pkg
// Types, codes and fixed header offsets shared by the IPv4 filter blocks.
// ============================================================================
package ipvf_pkg;

    // A header length (IHL * 4) always fits in six bits.
    localparam int HDR_LEN_W  = 6;
    localparam int SUM_W      = 21;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [HDR_LEN_W-1:0] MIN_HDR_BYTES = 6'd20;

    localparam logic [HDR_LEN_W-1:0] POS_TTL       = 6'd8;
    localparam logic [HDR_LEN_W-1:0] POS_CK_HI     = 6'd10;
    localparam logic [HDR_LEN_W-1:0] POS_CK_LO     = 6'd11;
    localparam logic [HDR_LEN_W-1:0] POS_SRC_FIRST = 6'd12;
    localparam logic [HDR_LEN_W-1:0] POS_SRC_LAST  = 6'd15;
    localparam logic [HDR_LEN_W-1:0] POS_DST_FIRST = 6'd16;
    localparam logic [HDR_LEN_W-1:0] POS_DST_LAST  = 6'd19;

    localparam logic [7:0] TTL_MIN_FWD = 8'd1;

    localparam logic [CFG_DATA_W-1:0] RST_BLOCK_SRC = 32'hC0A8_0203;
    localparam logic [CFG_DATA_W-1:0] RST_BLOCK_DST = 32'hC0A8_0201;
    localparam logic [CFG_DATA_W-1:0] RST_ALLOW_SRC = 32'hC0A8_0204;
    localparam logic [CFG_DATA_W-1:0] RST_ALLOW_DST = 32'hC0A8_0201;

    typedef enum logic [2:0] {
        V_DEFAULT   = 3'd0,
        V_ALLOW     = 3'd1,
        V_BLOCK     = 3'd2,
        V_TTL       = 3'd3,
        V_MALFORMED = 3'd4
    } t_verdict;

    typedef enum logic {
        K_DATA   = 1'b0,
        K_NOTICE = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SRC = 2'd0,
        REG_BLOCK_DST = 2'd1,
        REG_ALLOW_SRC = 2'd2,
        REG_ALLOW_DST = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DECIDE,
        ST_EMIT,
        ST_PASS,
        ST_DISCARD
    } t_state;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       out_last;
        t_verdict   verdict;
    } t_out_item;

    typedef struct packed {
        logic                 en;
        logic [HDR_LEN_W-1:0] pos;
        logic [7:0]           data;
    } t_tap_ctl;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  ttl;
        logic [15:0] csum;
    } t_hdr_fields;

endpackage

FILE: rtl/ipvf_stream_if.sv
// ============================================================================
// ipvf_stream_if
// Valid/ready stream channel carrying one item of type T per handshake.
// ============================================================================
interface ipvf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ipvf_hdr_ram.sv
// ============================================================================
// ipvf_hdr_ram
// Header byte store: one write port, one read port, registered read data.
// ============================================================================
module ipvf_hdr_ram #(
    parameter int DEPTH = 60,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_re,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/ipvf_hdr_tap.sv
// ============================================================================
// ipvf_hdr_tap
// Captures TTL and addresses as header bytes arrive and accumulates the
// rebuilt header checksum.
// ============================================================================
module ipvf_hdr_tap
    import ipvf_pkg::*;
(
    input  logic        i_clk,
    input  t_tap_ctl    i_ctl,
    output t_hdr_fields o_fields
);
    logic [SUM_W-1:0] r_sum;
    logic [7:0]       r_hi;
    logic [7:0]       r_ttl;
    logic [31:0]      r_src;
    logic [31:0]      r_dst;
    logic [7:0]       w_lo;
    logic [16:0]      w_fold1;
    logic [15:0]      w_fold2;

    // The sum already sees the decremented TTL and a zero checksum field.
    assign w_lo = (i_ctl.pos == POS_CK_LO) ? 8'd0 : i_ctl.data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (!i_ctl.pos[0]) begin
                if (i_ctl.pos == POS_TTL) begin
                    r_hi <= i_ctl.data - 8'd1;
                end else if (i_ctl.pos == POS_CK_HI) begin
                    r_hi <= 8'd0;
                end else begin
                    r_hi <= i_ctl.data;
                end
                if (i_ctl.pos == '0) begin
                    r_sum <= '0;
                end
            end else begin
                r_sum <= r_sum + SUM_W'({r_hi, w_lo});
            end
            if (i_ctl.pos == POS_TTL) begin
                r_ttl <= i_ctl.data;
            end
            if (i_ctl.pos inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
                r_src <= {r_src[23:0], i_ctl.data};
            end
            if (i_ctl.pos inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
                r_dst <= {r_dst[23:0], i_ctl.data};
            end
        end
    end

    assign w_fold1 = 17'(r_sum[15:0]) + 17'(r_sum[SUM_W-1:16]);
    assign w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);

    assign o_fields.src  = r_src;
    assign o_fields.dst  = r_dst;
    assign o_fields.ttl  = r_ttl;
    assign o_fields.csum = ~w_fold2;
endmodule

FILE: rtl/ipv4_filter_ttl_forward.sv
// ============================================================================
// ipv4_filter_ttl_forward
// IPv4 filter: buffers the header, drops by rule, TTL or malformation,
// otherwise forwards with TTL decremented and the checksum rebuilt.
// ============================================================================
// Header bytes are taken one item per cycle while the output slot is free;
// a decision state follows. The forwarded header leaves one byte per cycle
// while the output accepts, read from the registered RAM; input stalls then.
// Payload bytes pass via the output register, one item per cycle when free.
// Reset clears control state and restores the rule registers; the header
// RAM is not cleared, since a packet only reads bytes it has written.
module ipv4_filter_ttl_forward
    import ipvf_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 60
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipvf_stream_if.sink           i_in,
    ipvf_stream_if.source         o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int PW = $clog2(MAX_HEADER_BYTES);

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic [PW-1:0]         r_pos, n_pos;
    logic [HDR_LEN_W-1:0]  r_len, n_len;
    logic                  r_last_hdr, n_last_hdr;
    logic                  r_fwd, n_fwd;
    logic [HDR_LEN_W-1:0]  r_issue, n_issue;
    logic [HDR_LEN_W-1:0]  r_emit_idx, n_emit_idx;
    logic                  r_rd_pend, n_rd_pend;

    logic [CFG_DATA_W-1:0] r_blk_src, r_blk_dst, r_alw_src, r_alw_dst;

    logic                  w_slot;
    logic                  w_in_acc;
    logic [HDR_LEN_W-1:0]  w_ihl_len;
    logic                  w_first;
    logic                  w_bad_ihl;
    logic [HDR_LEN_W-1:0]  w_cur_len;
    logic [HDR_LEN_W:0]    w_pos_nx;
    logic                  w_more;
    logic                  w_blocked;
    logic                  w_allowed;
    logic                  w_ttl_exp;
    logic                  w_load;
    logic                  w_final;
    logic                  w_issue;
    logic                  w_mem_we;
    logic [7:0]            w_rd_data;
    logic [7:0]            w_emit_byte;
    t_tap_ctl              w_tap;
    t_hdr_fields           w_fields;
    t_verdict              w_fwd_verdict;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_src <= RST_BLOCK_SRC;
            r_blk_dst <= RST_BLOCK_DST;
            r_alw_src <= RST_ALLOW_SRC;
            r_alw_dst <= RST_ALLOW_DST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_SRC: r_blk_src <= i_cfg_data;
                REG_BLOCK_DST: r_blk_dst <= i_cfg_data;
                REG_ALLOW_SRC: r_alw_src <= i_cfg_data;
                REG_ALLOW_DST: r_alw_dst <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------------- decode
    assign w_slot    = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_COLLECT || r_state == ST_PASS) ? w_slot
                                                                      : (r_state == ST_DISCARD);
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_ihl_len = {i_in.data.in_byte[3:0], 2'b00};
    assign w_first   = (r_pos == '0);
    assign w_bad_ihl = w_first && (w_ihl_len < MIN_HDR_BYTES ||
                                   w_ihl_len > HDR_LEN_W'(MAX_HEADER_BYTES));
    assign w_cur_len = w_first ? w_ihl_len : r_len;
    assign w_pos_nx  = (HDR_LEN_W+1)'(r_pos) + 1'b1;
    assign w_more    = w_pos_nx < {1'b0, w_cur_len};

    assign w_blocked = (w_fields.src == r_blk_src) && (w_fields.dst == r_blk_dst);
    assign w_allowed = (w_fields.src == r_alw_src) && (w_fields.dst == r_alw_dst);
    assign w_ttl_exp = (w_fields.ttl <= TTL_MIN_FWD);

    assign w_load  = r_rd_pend && w_slot;
    assign w_final = (r_emit_idx == r_len - 1'b1);
    assign w_issue = (r_issue < r_len) && (!r_rd_pend || w_load);

    assign w_fwd_verdict = r_fwd ? V_ALLOW : V_DEFAULT;

    always_comb begin
        if (r_emit_idx == POS_TTL) begin
            w_emit_byte = w_fields.ttl - 8'd1;
        end else if (r_emit_idx == POS_CK_HI) begin
            w_emit_byte = w_fields.csum[15:8];
        end else if (r_emit_idx == POS_CK_LO) begin
            w_emit_byte = w_fields.csum[7:0];
        end else begin
            w_emit_byte = w_rd_data;
        end
    end

    assign w_mem_we = w_in_acc && (r_state == ST_COLLECT) && !w_bad_ihl;

    assign w_tap.en   = w_mem_we;
    assign w_tap.pos  = HDR_LEN_W'(r_pos);
    assign w_tap.data = i_in.data.in_byte;

    // ----------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (w_in_acc) begin
                    if (w_bad_ihl) begin
                        n_state = i_in.data.in_last ? ST_COLLECT : ST_DISCARD;
                    end else if (!w_more) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (w_slot) begin
                    if (w_blocked || w_ttl_exp) begin
                        n_state = r_last_hdr ? ST_COLLECT : ST_DISCARD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_load && w_final) begin
                    n_state = r_last_hdr ? ST_COLLECT : ST_PASS;
                end
            end
            ST_PASS, ST_DISCARD: begin
                if (w_in_acc && i_in.data.in_last) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        n_pos       = r_pos;
        n_len       = r_len;
        n_last_hdr  = r_last_hdr;
        n_fwd       = r_fwd;
        n_issue     = r_issue;
        n_emit_idx  = r_emit_idx;
        n_rd_pend   = r_rd_pend;
        case (r_state)
            ST_COLLECT: begin
                if (w_in_acc) begin
                    if (w_bad_ihl) begin
                        n_out_valid = 1'b1;
                        n_out       = '{K_NOTICE, 8'd0, 1'b1, V_MALFORMED};
                        n_pos       = '0;
                    end else begin
                        n_len = w_cur_len;
                        if (w_more && i_in.data.in_last) begin
                            // Packet ended inside its header.
                            n_out_valid = 1'b1;
                            n_out       = '{K_NOTICE, 8'd0, 1'b1, V_MALFORMED};
                            n_pos       = '0;
                        end else if (w_more) begin
                            n_pos = r_pos + 1'b1;
                        end else begin
                            n_pos      = '0;
                            n_last_hdr = i_in.data.in_last;
                        end
                    end
                end
            end
            ST_DECIDE: begin
                if (w_slot) begin
                    if (w_blocked) begin
                        n_out_valid = 1'b1;
                        n_out       = '{K_NOTICE, 8'd0, 1'b1, V_BLOCK};
                    end else begin
                        n_fwd = w_allowed;
                        if (w_ttl_exp) begin
                            n_out_valid = 1'b1;
                            n_out       = '{K_NOTICE, 8'd0, 1'b1, V_TTL};
                        end else begin
                            n_issue   = '0;
                            n_rd_pend = 1'b0;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out       = '{K_DATA, w_emit_byte, r_last_hdr && w_final,
                                    w_fwd_verdict};
                    n_rd_pend   = 1'b0;
                end
                if (w_issue) begin
                    n_emit_idx = r_issue;
                    n_issue    = r_issue + 1'b1;
                    n_rd_pend  = 1'b1;
                end
            end
            ST_PASS: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '{K_DATA, i_in.data.in_byte, i_in.data.in_last,
                                    w_fwd_verdict};
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_last_hdr  <= 1'b0;
            r_fwd       <= 1'b0;
            r_issue     <= '0;
            r_emit_idx  <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_last_hdr  <= n_last_hdr;
            r_fwd       <= n_fwd;
            r_issue     <= n_issue;
            r_emit_idx  <= n_emit_idx;
            r_rd_pend   <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // -------------------------------------------------------------- submodules
    ipvf_hdr_ram #(
        .DEPTH (MAX_HEADER_BYTES),
        .AW    (PW)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_wr_addr (r_pos),
        .i_wr_data (i_in.data.in_byte),
        .i_re      ((r_state == ST_EMIT) && w_issue),
        .i_rd_addr (r_issue[PW-1:0]),
        .o_rd_data (w_rd_data)
    );

    ipvf_hdr_tap u_hdr_tap (
        .i_clk    (i_clk),
        .i_ctl    (w_tap),
        .o_fields (w_fields)
    );
endmodule

FILE: rtl/ipvf_chk.sv
// ============================================================================
// ipvf_chk
// Port-level checks on the result stream of the IPv4 filter.
// ============================================================================
module ipvf_chk
    import ipvf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      i_ready,
    input t_out_item i_item
);
    // A drop notice is always a single closing item with no data.
    a_notice_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind == K_NOTICE |-> i_item.out_last && i_item.out_byte == 8'd0)
        else $error("drop notice with data or without last");

    a_data_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind == K_DATA |->
            i_item.verdict == V_DEFAULT || i_item.verdict == V_ALLOW)
        else $error("forwarded item carries a drop verdict");

    a_notice_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind == K_NOTICE |->
            i_item.verdict == V_BLOCK || i_item.verdict == V_TTL ||
            i_item.verdict == V_MALFORMED)
        else $error("drop notice carries a forward verdict");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_item))
        else $error("stalled result item changed");
endmodule

bind ipv4_filter_ttl_forward ipvf_chk u_ipvf_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_item  (o_out.data)
);

FILE: bench/ipv4_filter_ttl_forward_test.sv
// ============================================================================
// ipv4_filter_ttl_forward_test
// Self-checking bench for the IPv4 TTL-forward filter. Packets are fed one
// byte per item and every result item is compared with a local prediction
// of the filter: drop notices for malformed, blocked and expired packets,
// and forwarded bytes with the TTL decremented and the header checksum
// rebuilt. Both channels idle and stall at random, and the rule registers
// are rewritten between phases while the filter is idle.
// ============================================================================
module ipv4_filter_ttl_forward_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ipvf_pkg::*;

    localparam int HDR_BYTES_MAX = 60;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 12;

    localparam logic [31:0] HOST_A = 32'h0A00_0001;
    localparam logic [31:0] HOST_B = 32'h0A00_00FE;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ALL_ZEROS = 32'h0000_0000;

    typedef enum logic [1:0] {
        PKT_HEADER,
        PKT_PASS,
        PKT_DISCARD
    } t_pkt_phase;

    typedef struct {
        logic [7:0]  lead_byte;
        logic [7:0]  ttl;
        logic [31:0] src;
        logic [31:0] dst;
        int          len;
        bit          typed;
        t_verdict    notice;
    } t_pkt_row;

    // Rows marked typed carry their drop notice here; the others are predicted.
    t_pkt_row pkt_rows [10] = '{
        '{8'h40, 8'h40, HOST_A, HOST_B, 1, 1'b1, V_MALFORMED},
        '{8'h44, 8'h40, HOST_A, HOST_B, 4, 1'b1, V_MALFORMED},
        '{8'h45, 8'h40, HOST_A, HOST_B, 19, 1'b1, V_MALFORMED},
        '{8'h46, 8'h00, RST_BLOCK_SRC, RST_BLOCK_DST, 26, 1'b1, V_BLOCK},
        '{8'h45, 8'h01, RST_ALLOW_SRC, RST_ALLOW_DST, 20, 1'b1, V_TTL},
        '{8'h45, 8'h02, HOST_A, HOST_B, 20, 1'b0, V_DEFAULT},
        '{8'h4F, 8'hFF, RST_ALLOW_SRC, RST_ALLOW_DST, 60, 1'b0, V_DEFAULT},
        '{8'hF5, 8'h09, RST_BLOCK_SRC, 32'hC0A8_0202, 21, 1'b0, V_DEFAULT},
        '{8'h05, 8'h80, ALL_ONES, ALL_ZEROS, 22, 1'b0, V_DEFAULT},
        '{8'h46, 8'h7F, RST_ALLOW_SRC, HOST_B, 27, 1'b0, V_DEFAULT}
    };

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = REG_BLOCK_SRC;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ipvf_stream_if #(.T(t_in_item))  in_ch ();
    ipvf_stream_if #(.T(t_out_item)) out_ch ();

    ipv4_filter_ttl_forward #(
        .MAX_HEADER_BYTES(HDR_BYTES_MAX)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Filter prediction state.
    logic [31:0] rule_block_src;
    logic [31:0] rule_block_dst;
    logic [31:0] rule_allow_src;
    logic [31:0] rule_allow_dst;
    logic [7:0]  hdr_buf [HDR_BYTES_MAX];
    int unsigned hdr_pos;
    int unsigned hdr_len;
    t_pkt_phase  pkt_phase;
    t_verdict    fwd_verdict;
    bit          quiet_prediction = 1'b0;
    t_out_item   expected_q [$];

    int        idle_pct = 0;
    bit        hold_request = 1'b0;
    int        n_errors = 0;
    int        n_bytes = 0;
    int        n_packets = 0;
    int        n_fwd = 0;
    int        n_allow = 0;
    int        n_notice [5] = '{0, 0, 0, 0, 0};
    t_out_item got_item;
    t_out_item want_item;

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 15);
        return $urandom_range(3, 1);
    endfunction

    function automatic void filter_reset();
        rule_block_src = RST_BLOCK_SRC;
        rule_block_dst = RST_BLOCK_DST;
        rule_allow_src = RST_ALLOW_SRC;
        rule_allow_dst = RST_ALLOW_DST;
        hdr_pos = 0;
        hdr_len = 0;
        pkt_phase = PKT_HEADER;
        fwd_verdict = V_DEFAULT;
    endfunction

    function automatic void push_result(t_kind kind, logic [7:0] data, logic is_last,
                                        t_verdict verdict);
        t_out_item r;
        r.kind = kind;
        r.out_byte = data;
        r.out_last = is_last;
        r.verdict = verdict;
        if (!quiet_prediction)
            expected_q.push_back(r);
    endfunction

    function automatic void drop_packet(t_verdict verdict, logic is_last);
        push_result(K_NOTICE, 8'h00, 1'b1, verdict);
        pkt_phase = is_last ? PKT_HEADER : PKT_DISCARD;
        hdr_pos = 0;
    endfunction

    function automatic void filter_predict(t_in_item it);
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] sum;
        logic [15:0] csum;
        src = '0;
        dst = '0;
        sum = '0;
        case (pkt_phase)
            PKT_PASS: begin
                push_result(K_DATA, it.in_byte, it.in_last, fwd_verdict);
                if (it.in_last) begin
                    pkt_phase = PKT_HEADER;
                    hdr_pos = 0;
                end
            end
            PKT_DISCARD: begin
                if (it.in_last) begin
                    pkt_phase = PKT_HEADER;
                    hdr_pos = 0;
                end
            end
            default: begin
                if (hdr_pos == 0) begin
                    hdr_len = it.in_byte[3:0] * 4;
                    if (hdr_len < MIN_HDR_BYTES || hdr_len > HDR_BYTES_MAX) begin
                        drop_packet(V_MALFORMED, it.in_last);
                        return;
                    end
                end
                hdr_buf[hdr_pos] = it.in_byte;
                hdr_pos++;
                if (hdr_pos < hdr_len) begin
                    if (it.in_last)
                        drop_packet(V_MALFORMED, 1'b1);
                    return;
                end

                hdr_pos = 0;
                for (int k = 0; k < 4; k++) begin
                    src = {src[23:0], hdr_buf[int'(POS_SRC_FIRST) + k]};
                    dst = {dst[23:0], hdr_buf[int'(POS_DST_FIRST) + k]};
                end
                if (src == rule_block_src && dst == rule_block_dst) begin
                    drop_packet(V_BLOCK, it.in_last);
                    return;
                end
                fwd_verdict = (src == rule_allow_src && dst == rule_allow_dst) ?
                              V_ALLOW : V_DEFAULT;
                if (hdr_buf[POS_TTL] <= TTL_MIN_FWD) begin
                    drop_packet(V_TTL, it.in_last);
                    return;
                end

                hdr_buf[POS_TTL] = hdr_buf[POS_TTL] - 8'd1;
                hdr_buf[POS_CK_HI] = 8'h00;
                hdr_buf[POS_CK_LO] = 8'h00;
                for (int k = 0; k < hdr_len; k += 2)
                    sum += {hdr_buf[k], hdr_buf[k + 1]};
                sum = (sum >> 16) + (sum & 32'h0000_FFFF);
                sum = sum + (sum >> 16);
                csum = ~sum[15:0];
                hdr_buf[POS_CK_HI] = csum[15:8];
                hdr_buf[POS_CK_LO] = csum[7:0];

                for (int k = 0; k < hdr_len; k++)
                    push_result(K_DATA, hdr_buf[k], it.in_last && (k + 1 == hdr_len),
                                fwd_verdict);
                pkt_phase = it.in_last ? PKT_HEADER : PKT_PASS;
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        filter_predict(it);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] lead_byte, input logic [7:0] ttl,
                               input logic [31:0] src, input logic [31:0] dst,
                               input int len);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                it.in_byte = lead_byte;
            else if (i == int'(POS_TTL))
                it.in_byte = ttl;
            else if (i >= int'(POS_SRC_FIRST) && i <= int'(POS_SRC_LAST))
                it.in_byte = 8'(src >> (8 * (int'(POS_SRC_LAST) - i)));
            else if (i >= int'(POS_DST_FIRST) && i <= int'(POS_DST_LAST))
                it.in_byte = 8'(dst >> (8 * (int'(POS_DST_LAST) - i)));
            else
                it.in_byte = 8'($urandom);
            it.in_last = (i == len - 1);
            send_byte(it);
        end
        n_packets++;
    endtask

    task automatic random_packet();
        logic [7:0]  lead_byte;
        logic [7:0]  ttl;
        logic [31:0] src;
        logic [31:0] dst;
        int          kind_sel;
        int          pick;
        int          hdr;
        int          len;
        kind_sel = $urandom_range(99);
        lead_byte = 8'($urandom);
        if (kind_sel < 15)
            lead_byte[3:0] = 4'($urandom_range(4));
        else if ($urandom_range(3) != 0)
            lead_byte[3:0] = 4'd5;
        else
            lead_byte[3:0] = 4'($urandom_range(15, 6));
        hdr = lead_byte[3:0] * 4;

        pick = $urandom_range(9);
        if (pick == 0)
            ttl = 8'($urandom_range(1));
        else if (pick == 1)
            ttl = ($urandom_range(1) != 0) ? 8'hFF : 8'h02;
        else
            ttl = 8'($urandom_range(255, 2));

        src = $urandom;
        dst = $urandom;
        pick = $urandom_range(9);
        if (pick < 2) begin
            src = rule_block_src;
            dst = rule_block_dst;
        end else if (pick < 4) begin
            src = rule_allow_src;
            dst = rule_allow_dst;
        end else if (pick == 4) begin
            src = rule_block_src;
        end else if (pick == 5) begin
            dst = rule_allow_dst;
        end

        if (kind_sel < 15)
            len = $urandom_range(5, 1);
        else if (kind_sel < 27)
            len = $urandom_range(hdr - 1, 1);
        else if ($urandom_range(9) == 0)
            len = hdr + $urandom_range(40, 9);
        else
            len = hdr + $urandom_range(6);
        send_packet(lead_byte, ttl, src, dst, len);
    endtask

    task automatic random_phase(input int min_bytes);
        int start;
        start = n_bytes;
        while (n_bytes - start < min_bytes)
            random_packet();
    endtask

    // Waits until every expected result has arrived or DRAIN_LIMIT runs out,
    // then lets the filter finish with input idle before the rules change.
    task automatic settle();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BLOCK_SRC: rule_block_src = value;
            REG_BLOCK_DST: rule_block_dst = value;
            REG_ALLOW_SRC: rule_allow_src = value;
            REG_ALLOW_DST: rule_allow_dst = value;
            default: ;
        endcase
    endtask

    task automatic set_rules(input logic [31:0] block_src, input logic [31:0] block_dst,
                             input logic [31:0] allow_src, input logic [31:0] allow_dst);
        cfg_write(REG_BLOCK_SRC, block_src);
        cfg_write(REG_BLOCK_DST, block_dst);
        cfg_write(REG_ALLOW_SRC, allow_src);
        cfg_write(REG_ALLOW_DST, allow_dst);
    endtask

    initial begin : stimulus
        logic [31:0] pair_src;
        logic [31:0] pair_dst;
        t_out_item   notice;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        filter_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 25;
        foreach (pkt_rows[r]) begin
            if (pkt_rows[r].typed) begin
                notice.kind = K_NOTICE;
                notice.out_byte = 8'h00;
                notice.out_last = 1'b1;
                notice.verdict = pkt_rows[r].notice;
                expected_q.push_back(notice);
                quiet_prediction = 1'b1;
            end
            send_packet(pkt_rows[r].lead_byte, pkt_rows[r].ttl, pkt_rows[r].src,
                        pkt_rows[r].dst, pkt_rows[r].len);
            quiet_prediction = 1'b0;
        end
        settle();

        set_rules(ALL_ZEROS, ALL_ZEROS, ALL_ONES, ALL_ONES);
        idle_pct = 30;
        random_phase(PHASE_BYTES);
        settle();

        // No idling here; the output side is held off once to fill the filter.
        set_rules(ALL_ONES, ALL_ONES, ALL_ZEROS, ALL_ZEROS);
        idle_pct = 0;
        hold_request = 1'b1;
        random_phase(PHASE_BYTES);
        settle();

        set_rules($urandom, $urandom, $urandom, $urandom);
        idle_pct = 50;
        random_phase(PHASE_BYTES);
        settle();

        // Identical block and allow rules: the block rule must win.
        pair_src = $urandom;
        pair_dst = $urandom;
        set_rules(pair_src, pair_dst, pair_src, pair_dst);
        idle_pct = 20;
        random_phase(PHASE_BYTES);
        settle();

        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            n_errors += expected_q.size();
        end
        $display("Sent %0d bytes in %0d packets under five rule settings, with random gaps",
                 n_bytes, n_packets);
        $display("and one long output hold; checked %0d forwarded bytes (%0d allow-tagged), %0d %s",
                 n_fwd, n_allow, n_notice[V_BLOCK] + n_notice[V_TTL] + n_notice[V_MALFORMED],
                 "drop notices");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_item = out_ch.data;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result kind=%0d byte=%02h last=%0b verdict=%0d",
                         $time, got_item.kind, got_item.out_byte, got_item.out_last,
                         got_item.verdict);
            end else begin
                want_item = expected_q.pop_front();
                if (got_item.kind !== want_item.kind ||
                    got_item.out_byte !== want_item.out_byte ||
                    got_item.out_last !== want_item.out_last ||
                    got_item.verdict !== want_item.verdict) begin
                    n_errors++;
                    $display({"%0t: mismatch, expected kind=%0d byte=%02h last=%0b ",
                              "verdict=%0d, got kind=%0d byte=%02h last=%0b verdict=%0d"},
                             $time, want_item.kind, want_item.out_byte,
                             want_item.out_last, want_item.verdict, got_item.kind,
                             got_item.out_byte, got_item.out_last, got_item.verdict);
                end else if (got_item.kind == K_NOTICE) begin
                    n_notice[got_item.verdict]++;
                end else begin
                    n_fwd++;
                    if (got_item.verdict == V_ALLOW)
                        n_allow++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
